// ===== hw/rtl/msw_pkg.sv =====
package msw_pkg;

    localparam int DATA_W = 32;
    localparam int SLOT_W = 6;
    localparam int CMD_W  = 2;
    localparam int STS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_KICK    = 2'd3;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_REFUSED = 2'd1;
    localparam logic [STS_W-1:0] STS_EXPIRED = 2'd2;

    // One access to the slot table per cycle.
    typedef struct packed {
        logic [SLOT_W-1:0] addr;
        logic              rd_en;    // read timeout and last kick
        logic              wr_claim; // write both words, mark active
        logic              wr_kick;  // write last kick only
        logic              clr;      // mark free
        logic [DATA_W-1:0] timeout;
        logic [DATA_W-1:0] tick;
    } t_mem_req;

endpackage

// ===== hw/rtl/msw_if.sv =====
interface msw_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [msw_pkg::CMD_W-1:0]      command;
    logic [msw_pkg::SLOT_W-1:0]     slot;
    logic [msw_pkg::DATA_W-1:0]     interval;

    modport source (output valid, output command, output slot, output interval,
                    input ready);
    modport sink   (input valid, input command, input slot, input interval,
                    output ready);
endinterface

interface msw_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [msw_pkg::STS_W-1:0]      status;
    logic [msw_pkg::SLOT_W-1:0]     slot_out;

    modport source (output valid, output status, output slot_out, input ready);
    modport sink   (input valid, input status, input slot_out, output ready);
endinterface

// ===== hw/rtl/msw_slot_mem.sv =====
module msw_slot_mem #(
    parameter int SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  msw_pkg::t_mem_req            i_req,
    output logic [SLOTS-1:0]             o_active,
    output logic [msw_pkg::DATA_W-1:0]   o_rd_timeout,
    output logic [msw_pkg::DATA_W-1:0]   o_rd_last_kick
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [msw_pkg::DATA_W-1:0] mem_timeout [SLOTS];
    logic [msw_pkg::DATA_W-1:0] mem_kick    [SLOTS];
    logic [SLOTS-1:0]           r_active;
    logic [IDX_W-1:0]           addr;

    assign addr     = i_req.addr[IDX_W-1:0];
    assign o_active = r_active;

    // Active bits: cleared at reset, so table words need no clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_req.wr_claim) begin
            r_active[addr] <= 1'b1;
        end else if (i_req.clr) begin
            r_active[addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_claim) begin
            mem_timeout[addr] <= i_req.timeout;
        end
        if (i_req.rd_en) begin
            o_rd_timeout <= mem_timeout[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_claim || i_req.wr_kick) begin
            mem_kick[addr] <= i_req.tick;
        end
        if (i_req.rd_en) begin
            o_rd_last_kick <= mem_kick[addr];
        end
    end

endmodule

// ===== hw/rtl/multi_slot_watchdog.sv =====
// Channel  | Dir | Beat fields                      | Accepted when
// i_cmd    | in  | command, slot, interval          | valid && ready
// o_rsp    | out | status, slot_out                 | valid && ready
//
// One command is in work at a time; every command gives exactly one response beat.
// Work from the accepting edge to the response in the output register: tick reads
// the table once per slot, compares each slot in the cycle after its read and stops
// at the first expired slot; request tests one active bit per cycle and stops at the
// first free slot; free, kick and zero-interval requests go straight to the done state.
// Reset (synchronous, active low) clears the tick counter and all active bits.
// A finished response waits in the output register; the next command is taken
// meanwhile and holds in its final state until the output register frees.
module multi_slot_watchdog #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msw_cmd_if.sink     i_cmd,
    msw_rsp_if.source   o_rsp
);
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                       r_state, n_state;
    logic [msw_pkg::CMD_W-1:0]        r_op, n_op;
    logic [msw_pkg::DATA_W-1:0]       r_tick, n_tick;
    logic [msw_pkg::DATA_W-1:0]       r_interval, n_interval;
    logic [CNT_W-1:0]                 r_idx, n_idx;
    logic                             r_chk_vld, n_chk_vld;
    logic                             r_chk_act, n_chk_act;
    logic [IDX_W-1:0]                 r_chk_idx, n_chk_idx;
    logic [msw_pkg::STS_W-1:0]        r_res_status, n_res_status;
    logic [msw_pkg::SLOT_W-1:0]       r_res_slot, n_res_slot;
    logic                             r_out_vld, n_out_vld;
    logic [msw_pkg::STS_W-1:0]        r_out_status, n_out_status;
    logic [msw_pkg::SLOT_W-1:0]       r_out_slot, n_out_slot;

    msw_pkg::t_mem_req                mem_req;
    logic [SLOTS-1:0]                 active;
    logic [msw_pkg::DATA_W-1:0]       rd_timeout;
    logic [msw_pkg::DATA_W-1:0]       rd_last_kick;
    logic [msw_pkg::DATA_W-1:0]       age;
    logic                             cmd_beat;
    logic                             slot_ok;
    logic                             scan_more;
    logic                             scan_last;
    logic [IDX_W-1:0]                 scan_idx;

    msw_slot_mem #(.SLOTS(SLOTS)) u_mem (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (mem_req),
        .o_active       (active),
        .o_rd_timeout   (rd_timeout),
        .o_rd_last_kick (rd_last_kick)
    );

    assign i_cmd.ready    = (r_state == ST_IDLE);
    assign cmd_beat       = i_cmd.valid && i_cmd.ready;
    assign slot_ok        = (i_cmd.slot < msw_pkg::SLOT_W'(SLOTS));
    assign scan_more      = (r_idx < CNT_W'(SLOTS));
    assign scan_last      = (r_idx == CNT_W'(SLOTS - 1));
    assign scan_idx       = r_idx[IDX_W-1:0];
    assign age            = r_tick - rd_last_kick;

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.slot_out = r_out_slot;

    // Table access for the current cycle.
    always_comb begin
        mem_req         = '0;
        mem_req.tick    = r_tick;
        mem_req.timeout = r_interval;
        if (r_state == ST_IDLE) begin
            mem_req.addr = i_cmd.slot;
            if (cmd_beat && slot_ok) begin
                // Kick refreshes only an active slot; free drops the active bit.
                mem_req.wr_kick = (i_cmd.command == msw_pkg::CMD_KICK)
                                  && active[i_cmd.slot[IDX_W-1:0]];
                mem_req.clr     = (i_cmd.command == msw_pkg::CMD_FREE);
            end
        end else if (r_state == ST_SCAN) begin
            mem_req.addr = msw_pkg::SLOT_W'(r_idx);
            if (r_op == msw_pkg::CMD_TICK) begin
                mem_req.rd_en = scan_more;
            end else begin
                mem_req.wr_claim = scan_more && !active[scan_idx];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_tick       = r_tick;
        n_interval   = r_interval;
        n_idx        = r_idx;
        n_chk_vld    = 1'b0;
        n_chk_act    = r_chk_act;
        n_chk_idx    = r_chk_idx;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;

        unique case (r_state)
            ST_IDLE: begin
                if (cmd_beat) begin
                    n_op         = i_cmd.command;
                    n_interval   = i_cmd.interval;
                    n_idx        = '0;
                    n_res_status = msw_pkg::STS_OK;
                    n_res_slot   = '0;
                    unique case (i_cmd.command)
                        msw_pkg::CMD_TICK: begin
                            // Advance the counter first; the scan sees the new value.
                            n_tick  = r_tick + 1'b1;
                            n_state = ST_SCAN;
                        end
                        msw_pkg::CMD_REQUEST: begin
                            if (i_cmd.interval == '0) begin
                                n_res_status = msw_pkg::STS_REFUSED;
                                n_state      = ST_DONE;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            // Free and kick finish in the table write above.
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_op == msw_pkg::CMD_TICK) begin
                    // Issue stage: read slot r_idx, remember its active bit.
                    if (scan_more) begin
                        n_idx     = r_idx + 1'b1;
                        n_chk_vld = 1'b1;
                        n_chk_act = active[scan_idx];
                        n_chk_idx = scan_idx;
                    end
                    // Check stage: slot read in the previous cycle.
                    if (r_chk_vld) begin
                        if (r_chk_act && (age > rd_timeout)) begin
                            n_res_status = msw_pkg::STS_EXPIRED;
                            n_res_slot   = msw_pkg::SLOT_W'(r_chk_idx);
                            n_state      = ST_DONE;
                        end else if (r_chk_idx == IDX_W'(SLOTS - 1)) begin
                            n_state = ST_DONE;
                        end
                    end
                end else begin
                    // Request: claim the first free slot, else refuse at the end.
                    if (!active[scan_idx]) begin
                        n_res_slot = msw_pkg::SLOT_W'(r_idx);
                        n_state    = ST_DONE;
                    end else if (scan_last) begin
                        n_res_status = msw_pkg::STS_REFUSED;
                        n_state      = ST_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = r_res_slot;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tick    <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tick    <= n_tick;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_interval   <= n_interval;
        r_idx        <= n_idx;
        r_chk_act    <= n_chk_act;
        r_chk_idx    <= n_chk_idx;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
    end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int TAIL_ITEMS = 150;  // last beats run with no idling
    localparam int RAND_ITEMS = 1500;

    typedef struct packed {
        logic [msw_pkg::CMD_W-1:0]  command;
        logic [msw_pkg::SLOT_W-1:0] slot;
        logic [msw_pkg::DATA_W-1:0] interval;
    } t_cmd_beat;

    typedef struct packed {
        logic [msw_pkg::STS_W-1:0]  status;
        logic [msw_pkg::SLOT_W-1:0] slot_out;
    } t_rsp_beat;

    logic i_clk;
    logic i_rst_n;

    msw_cmd_if cmd_if ();
    msw_rsp_if rsp_if ();

    multi_slot_watchdog #(
        .SLOTS (SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Free-running clock, 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Commands waiting to be driven, and responses the watchdog still owes us.
    t_cmd_beat pending_cmds [$];
    t_rsp_beat owed_rsps [$];

    // Shadow copy of the watchdog: tick counter, interval per slot (zero = free)
    // and the tick value of the last kick per slot.
    logic [msw_pkg::DATA_W-1:0] wd_ticks;
    logic [msw_pkg::DATA_W-1:0] wd_limit  [SLOTS];
    logic [msw_pkg::DATA_W-1:0] wd_kicked [SLOTS];

    int mismatches  = 0;
    int total_cmds  = 32'h7fff_ffff;
    int sent_cmds   = 0;
    int cmd_gap     = 0;
    int rsp_stall   = 0;
    bit cmd_calm    = 1'b0;
    bit rsp_calm    = 1'b0;
    bit cmd_taken   = 1'b0;
    int cmd_count [4];
    int n_expired   = 0;
    int n_granted   = 0;
    int n_refused   = 0;

    // Advance the shadow watchdog by one command and return the response it owes.
    function automatic t_rsp_beat watchdog_step(t_cmd_beat b);
        t_rsp_beat r;
        r.status   = msw_pkg::STS_OK;
        r.slot_out = '0;
        case (b.command)
            msw_pkg::CMD_TICK: begin
                wd_ticks = wd_ticks + 1'b1;
                // Report only the lowest slot past its interval; the difference
                // wraps at 32 bits like the counter itself.
                for (int s = 0; s < SLOTS; s++) begin
                    if (wd_limit[s] != '0
                            && msw_pkg::DATA_W'(wd_ticks - wd_kicked[s]) > wd_limit[s])
                    begin
                        r.status   = msw_pkg::STS_EXPIRED;
                        r.slot_out = msw_pkg::SLOT_W'(s);
                        break;
                    end
                end
            end
            msw_pkg::CMD_REQUEST: begin
                // Zero interval or a full table: refuse and leave the table alone.
                r.status = msw_pkg::STS_REFUSED;
                if (b.interval != '0) begin
                    for (int s = 0; s < SLOTS; s++) begin
                        if (wd_limit[s] == '0) begin
                            wd_limit[s]  = b.interval;
                            wd_kicked[s] = wd_ticks;
                            r.status     = msw_pkg::STS_OK;
                            r.slot_out   = msw_pkg::SLOT_W'(s);
                            break;
                        end
                    end
                end
            end
            msw_pkg::CMD_FREE: begin
                // Out-of-range slots drop silently; freeing a free slot is harmless.
                if (b.slot < SLOTS) begin
                    wd_limit[b.slot]  = '0;
                    wd_kicked[b.slot] = '0;
                end
            end
            default: begin
                // Kick refreshes an active slot only.
                if (b.slot < SLOTS && wd_limit[b.slot] != '0)
                    wd_kicked[b.slot] = wd_ticks;
            end
        endcase
        return r;
    endfunction

    // Idle burst before the next command: none in calm stretches or the tail.
    function automatic int pick_cmd_gap();
        if (cmd_calm || sent_cmds >= total_cmds - TAIL_ITEMS)
            return 0;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, 17);
        return 0;
    endfunction

    // Mostly in range, now and then any 6-bit index.
    function automatic logic [msw_pkg::SLOT_W-1:0] pick_slot();
        if ($urandom_range(0, 99) < 85)
            return msw_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
        return msw_pkg::SLOT_W'($urandom_range(0, 63));
    endfunction

    // Short intervals so expiries happen often; the extremes now and then.
    function automatic logic [msw_pkg::DATA_W-1:0] pick_interval();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        if (roll < 18)
            return msw_pkg::DATA_W'($urandom());
        return msw_pkg::DATA_W'($urandom_range(1, 24));
    endfunction

    task automatic queue_cmd(logic [msw_pkg::CMD_W-1:0] command,
                             logic [msw_pkg::SLOT_W-1:0] slot,
                             logic [msw_pkg::DATA_W-1:0] interval);
        t_cmd_beat b;
        b.command  = command;
        b.slot     = slot;
        b.interval = interval;
        pending_cmds.push_back(b);
    endtask

    // Command driver: change on the falling edge, hold a beat until it is taken.
    always @(negedge i_clk) begin : cmd_driver
        t_cmd_beat nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (cmd_gap > 0) begin
                cmd_gap      <= cmd_gap - 1;
                cmd_if.valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                nxt = pending_cmds.pop_front();
                cmd_if.valid    <= 1'b1;
                cmd_if.command  <= nxt.command;
                cmd_if.slot     <= nxt.slot;
                cmd_if.interval <= nxt.interval;
                sent_cmds       <= sent_cmds + 1;
                cmd_gap         <= pick_cmd_gap();
                if ($urandom_range(0, 39) == 0)
                    cmd_calm <= !cmd_calm;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Response backpressure: random stall bursts, calm stretches, none in the tail.
    always @(negedge i_clk) begin : rsp_driver
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_stall > 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 199) == 0)
                rsp_calm <= !rsp_calm;
            if (!rsp_calm && sent_cmds < total_cmds - TAIL_ITEMS
                    && $urandom_range(0, 9) == 0)
                rsp_stall <= $urandom_range(1, 17);
        end
    end

    // Monitor: sample both channels on the rising edge. Check the response first
    // so a command taken on the same edge can never satisfy it.
    always @(posedge i_clk) begin : beat_monitor
        t_cmd_beat got_cmd;
        t_rsp_beat want;
        cmd_taken <= i_rst_n && cmd_if.valid && cmd_if.ready;
        if (!i_rst_n) begin
            wd_ticks = '0;
            for (int s = 0; s < SLOTS; s++) begin
                wd_limit[s]  = '0;
                wd_kicked[s] = '0;
            end
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_rsps.size() == 0) begin
                    $display("%0t: unexpected response beat: status %0d, slot_out %0d",
                             $time, rsp_if.status, rsp_if.slot_out);
                    mismatches++;
                end else begin
                    want = owed_rsps.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp_if.status);
                        mismatches++;
                    end
                    if (rsp_if.slot_out !== want.slot_out) begin
                        $display("%0t: slot_out mismatch: expected %0d, actual %0d",
                                 $time, want.slot_out, rsp_if.slot_out);
                        mismatches++;
                    end
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                got_cmd.command  = cmd_if.command;
                got_cmd.slot     = cmd_if.slot;
                got_cmd.interval = cmd_if.interval;
                want = watchdog_step(got_cmd);
                owed_rsps.push_back(want);
                cmd_count[got_cmd.command]++;
                if (want.status == msw_pkg::STS_EXPIRED)
                    n_expired++;
                else if (want.status == msw_pkg::STS_REFUSED)
                    n_refused++;
                else if (got_cmd.command == msw_pkg::CMD_REQUEST)
                    n_granted++;
            end
        end
    end

    // Stimulus: directed corner cases, then a random mix, then drain.
    initial begin : stimulus
        int roll;
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.command  = msw_pkg::CMD_TICK;
        cmd_if.slot     = '0;
        cmd_if.interval = '0;
        rsp_if.ready    = 1'b0;
        for (int c = 0; c < 4; c++)
            cmd_count[c] = 0;

        // Tick on an empty table, zero-interval refusal, grants at both
        // interval extremes (slot field ignored by request).
        queue_cmd(msw_pkg::CMD_TICK, '0, '0);
        queue_cmd(msw_pkg::CMD_REQUEST, '0, '0);
        queue_cmd(msw_pkg::CMD_REQUEST, '0, 32'd1);
        queue_cmd(msw_pkg::CMD_REQUEST, '1, '1);
        // Kick an active slot, kick a free one, out-of-range free and kick.
        queue_cmd(msw_pkg::CMD_KICK, '0, '1);
        queue_cmd(msw_pkg::CMD_KICK, 6'd5, '0);
        queue_cmd(msw_pkg::CMD_FREE, '1, '1);
        queue_cmd(msw_pkg::CMD_KICK, msw_pkg::SLOT_W'(SLOTS), '0);
        // Slot 0 has interval 1: first tick stays quiet, then it expires twice.
        queue_cmd(msw_pkg::CMD_TICK, '1, '1);
        queue_cmd(msw_pkg::CMD_TICK, '0, '0);
        queue_cmd(msw_pkg::CMD_TICK, '0, '0);
        // Free it, free it again, then fill the table and get refused.
        queue_cmd(msw_pkg::CMD_FREE, '0, '0);
        queue_cmd(msw_pkg::CMD_FREE, '0, '0);
        for (int s = 0; s < SLOTS; s++)
            queue_cmd(msw_pkg::CMD_REQUEST, '0, 32'd3);
        queue_cmd(msw_pkg::CMD_FREE, msw_pkg::SLOT_W'(SLOTS - 1), '0);

        // Random mix: plenty of ticks against short intervals, with kicks and
        // frees churning the table and requests refilling it.
        repeat (RAND_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
                queue_cmd(msw_pkg::CMD_TICK, msw_pkg::SLOT_W'($urandom()),
                          msw_pkg::DATA_W'($urandom()));
            else if (roll < 62)
                queue_cmd(msw_pkg::CMD_REQUEST, msw_pkg::SLOT_W'($urandom()),
                          pick_interval());
            else if (roll < 75)
                queue_cmd(msw_pkg::CMD_FREE, pick_slot(), msw_pkg::DATA_W'($urandom()));
            else
                queue_cmd(msw_pkg::CMD_KICK, pick_slot(), msw_pkg::DATA_W'($urandom()));
        end
        total_cmds = pending_cmds.size();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all beats sent and every owed response received.
        while (pending_cmds.size() != 0 || cmd_if.valid || owed_rsps.size() != 0)
            @(negedge i_clk);
        // Hold long enough for any stray response to show up.
        repeat (2 * SLOTS + 8) @(posedge i_clk);

        $display("Ran %0d commands: %0d ticks, %0d requests, %0d frees, %0d kicks.",
                 total_cmds, cmd_count[msw_pkg::CMD_TICK], cmd_count[msw_pkg::CMD_REQUEST],
                 cmd_count[msw_pkg::CMD_FREE], cmd_count[msw_pkg::CMD_KICK]);
        $display("Saw %0d expiries, %0d grants, %0d refusals; %0d mismatches.",
                 n_expired, n_granted, n_refused, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop far beyond the slowest legal run.
    initial begin : run_limit
        #2_000_000;
        $display("Timeout with %0d commands queued and %0d responses owed.",
                 pending_cmds.size(), owed_rsps.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/msw_pkg.sv
hw/rtl/msw_if.sv
hw/rtl/msw_slot_mem.sv
hw/rtl/multi_slot_watchdog.sv
sim/tb_top.sv
